### hw/rtl/lcd_pkg.sv
// Shared types, codes and saturation helpers for the lasso loading
// coordinate-descent block. No dependencies.
package lcd_pkg;

	// Item operation codes.
	localparam logic [2:0] OP_COV  = 3'd0;
	localparam logic [2:0] OP_MEAN = 3'd1;
	localparam logic [2:0] OP_RESP = 3'd2;
	localparam logic [2:0] OP_LOAD = 3'd3;
	localparam logic [2:0] OP_RUN  = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] REG_PENALTY = 2'd0;
	localparam logic [1:0] REG_PERSONS = 2'd1;
	localparam logic [1:0] REG_DIMS    = 2'd2;

	// Datapath commands, one per controller step.
	typedef enum logic [4:0] {
		DP_IDLE,
		DP_DIM_CLR,
		DP_HEAD_RD,
		DP_HEAD,
		DP_C1,
		DP_C2,
		DP_C3,
		DP_C4,
		DP_C5,
		DP_L_RD,
		DP_L_M1,
		DP_L_M2,
		DP_L_M3,
		DP_L_ACC,
		DP_T1,
		DP_T2,
		DP_D_SAT,
		DP_D_CMP,
		DP_D_DIV,
		DP_D_FIN,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   last;
	} lcd_cmd_t;

	typedef struct packed {
		logic out_busy;
		logic div_go;
		logic div_done;
	} lcd_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		begin
			if (v > 64'sh0000_0000_7FFF_FFFF)
				r = 32'sh7FFF_FFFF;
			else if (v < -64'sh0000_0000_8000_0000)
				r = 32'sh8000_0000;
			else
				r = v[31:0];
			return r;
		end
	endfunction

	// Doubling with saturation.
	function automatic logic signed [31:0] sat2(input logic signed [31:0] v);
		logic signed [63:0] d;
		begin
			d = 64'(v) + 64'(v);
			return sat32(d);
		end
	endfunction

endpackage

### hw/rtl/lcd_item_if.sv
// Input channel of the lasso loading block: one load or run word.
// Depends on nothing.
interface lcd_item_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic [9:0]         person;
	logic [2:0]         dim_a;
	logic [2:0]         dim_b;
	logic               response;
	logic signed [31:0] value;

	modport source (output valid, operation, person, dim_a, dim_b, response, value,
		input ready);
	modport sink (input valid, operation, person, dim_a, dim_b, response, value,
		output ready);
endinterface

### hw/rtl/lcd_result_if.sv
// Output channel of the lasso loading block: one loading word per dimension.
// Depends on nothing.
interface lcd_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         dimension;
	logic signed [31:0] loading;
	logic               last;
	logic               divide_fault;

	modport source (output valid, dimension, loading, last, divide_fault, input ready);
	modport sink (input valid, dimension, loading, last, divide_fault, output ready);
endinterface

### hw/rtl/lcd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing.
module lcd_div #(
	parameter int W = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [31:0]  divisor,
	output logic [W-1:0] quotient,
	output logic         done
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [31:0]   rem_q;
	logic [31:0]   dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [32:0]   shifted;
	logic          fits;

	assign shifted = {rem_q, quo_q[W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(shifted - {1'b0, dvs_q}) : shifted[31:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

### hw/rtl/lcd_ctrl.sv
// Sequencer of the lasso loading block: walks dimensions, persons and the
// inner dimension loop, and drives the datapath by command. Uses lcd_pkg.
module lcd_ctrl #(
	parameter int CNT_W = 11,
	parameter int DC_W  = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [2:0]        item_op,
	input  logic [CNT_W-1:0]  np,
	input  logic [DC_W-1:0]   nd,
	input  lcd_pkg::lcd_sts_t sts,
	output logic              item_ready,
	output lcd_pkg::lcd_cmd_t cmd,
	output logic [CNT_W-1:0]  person_idx,
	output logic [DC_W-1:0]   dim_k,
	output logic [DC_W-1:0]   dim_l
);
	typedef enum logic [4:0] {
		S_IDLE, S_DIM_CLR, S_HEAD_RD, S_HEAD, S_C1, S_C2, S_C3, S_C4, S_C5,
		S_L_NEXT, S_L_M1, S_L_M2, S_L_M3, S_L_ACC, S_T1, S_T2,
		S_D_SAT, S_D_CMP, S_D_DIV, S_D_FIN, S_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] i_q;
	logic [DC_W-1:0]  k_q;
	logic [DC_W-1:0]  l_q;
	logic             last_dim;

	assign last_dim = (k_q + DC_W'(1)) == nd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			k_q     <= '0;
			l_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid && item_op == lcd_pkg::OP_RUN) begin
						k_q     <= '0;
						state_q <= S_DIM_CLR;
					end
				end
				S_DIM_CLR: begin
					i_q     <= '0;
					state_q <= S_HEAD_RD;
				end
				S_HEAD_RD: state_q <= S_HEAD;
				S_HEAD:    state_q <= S_C1;
				S_C1:      state_q <= S_C2;
				S_C2:      state_q <= S_C3;
				S_C3:      state_q <= S_C4;
				S_C4:      state_q <= S_C5;
				S_C5: begin
					l_q     <= '0;
					state_q <= S_L_NEXT;
				end
				S_L_NEXT: begin
					if (l_q == nd) begin
						state_q <= S_T1;
					end else if (l_q == k_q) begin
						l_q <= l_q + DC_W'(1);
					end else begin
						state_q <= S_L_M1;
					end
				end
				S_L_M1: state_q <= S_L_M2;
				S_L_M2: state_q <= S_L_M3;
				S_L_M3: state_q <= S_L_ACC;
				S_L_ACC: begin
					l_q     <= l_q + DC_W'(1);
					state_q <= S_L_NEXT;
				end
				S_T1: state_q <= S_T2;
				S_T2: begin
					i_q <= i_q + CNT_W'(1);
					if ((i_q + CNT_W'(1)) == np)
						state_q <= S_D_SAT;
					else
						state_q <= S_HEAD_RD;
				end
				S_D_SAT: state_q <= S_D_CMP;
				S_D_CMP: state_q <= sts.div_go ? S_D_DIV : S_EMIT;
				S_D_DIV: begin
					if (sts.div_done)
						state_q <= S_D_FIN;
				end
				S_D_FIN: state_q <= S_EMIT;
				S_EMIT: begin
					if (!sts.out_busy) begin
						k_q     <= k_q + DC_W'(1);
						state_q <= last_dim ? S_IDLE : S_DIM_CLR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.last = last_dim;
		case (state_q)
			S_IDLE:    cmd.op = lcd_pkg::DP_IDLE;
			S_DIM_CLR: cmd.op = lcd_pkg::DP_DIM_CLR;
			S_HEAD_RD: cmd.op = lcd_pkg::DP_HEAD_RD;
			S_HEAD:    cmd.op = lcd_pkg::DP_HEAD;
			S_C1:      cmd.op = lcd_pkg::DP_C1;
			S_C2:      cmd.op = lcd_pkg::DP_C2;
			S_C3:      cmd.op = lcd_pkg::DP_C3;
			S_C4:      cmd.op = lcd_pkg::DP_C4;
			S_C5:      cmd.op = lcd_pkg::DP_C5;
			S_L_NEXT:  cmd.op = lcd_pkg::DP_L_RD;
			S_L_M1:    cmd.op = lcd_pkg::DP_L_M1;
			S_L_M2:    cmd.op = lcd_pkg::DP_L_M2;
			S_L_M3:    cmd.op = lcd_pkg::DP_L_M3;
			S_L_ACC:   cmd.op = lcd_pkg::DP_L_ACC;
			S_T1:      cmd.op = lcd_pkg::DP_T1;
			S_T2:      cmd.op = lcd_pkg::DP_T2;
			S_D_SAT:   cmd.op = lcd_pkg::DP_D_SAT;
			S_D_CMP:   cmd.op = lcd_pkg::DP_D_CMP;
			S_D_DIV:   cmd.op = lcd_pkg::DP_D_DIV;
			S_D_FIN:   cmd.op = lcd_pkg::DP_D_FIN;
			S_EMIT:    cmd.op = lcd_pkg::DP_EMIT;
			default:   cmd.op = lcd_pkg::DP_IDLE;
		endcase
	end

	assign item_ready = state_q == S_IDLE;
	assign person_idx = i_q;
	assign dim_k      = k_q;
	assign dim_l      = l_q;
endmodule

### hw/rtl/lcd_datapath.sv
// Datapath of the lasso loading block: person stores, loading row, shared
// multiplier, accumulators, threshold and divider, output register.
// Uses lcd_pkg and lcd_div.
module lcd_datapath #(
	parameter int MAX_PERSONS    = 1024,
	parameter int MAX_DIMENSIONS = 8,
	parameter int FRACTION_BITS  = 16,
	parameter int PW             = 10,
	parameter int DW             = 3,
	parameter int CNT_W          = 11,
	parameter int DC_W           = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [2:0]         operation,
	input  logic [9:0]         person,
	input  logic [2:0]         dim_a,
	input  logic [2:0]         dim_b,
	input  logic               response,
	input  logic signed [31:0] value,
	input  logic [30:0]        penalty,
	input  lcd_pkg::lcd_cmd_t  cmd,
	input  logic [CNT_W-1:0]   person_idx,
	input  logic [DC_W-1:0]    dim_k,
	input  logic [DC_W-1:0]    dim_l,
	output lcd_pkg::lcd_sts_t  sts,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [2:0]         out_dimension,
	output logic signed [31:0] out_loading,
	output logic               out_last,
	output logic               out_fault
);
	localparam int QW = 32 + FRACTION_BITS;
	localparam logic signed [31:0] HALF = 32'sd1 <<< (FRACTION_BITS - 1);

	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		begin
			p = 64'(a) * 64'(b);
			return lcd_pkg::sat32(p >>> FRACTION_BITS);
		end
	endfunction

	logic signed [31:0] cov_mem  [2**(PW + 2 * DW)];
	logic signed [31:0] mean_mem [2**(PW + DW)];
	logic signed [31:0] wt_mem   [2**PW];
	logic               resp_mem [2**PW];
	logic signed [31:0] row_q    [MAX_DIMENSIONS];

	logic [PW-1:0]      ld_p;
	logic [DW-1:0]      ld_a;
	logic [DW-1:0]      ld_b;
	logic               p_ok;
	logic               a_ok;
	logic               b_ok;
	logic [PW-1:0]      rd_p;
	logic [DW-1:0]      rd_r;
	logic [DW-1:0]      rd_k;

	logic signed [31:0] cov_rd_q;
	logic signed [31:0] mean_rd_q;
	logic signed [31:0] wt_rd_q;
	logic               resp_rd_q;

	logic signed [31:0] b_q;
	logic signed [31:0] muk_q;
	logic signed [31:0] eta_q;
	logic               resp_q;
	logic signed [31:0] covkk_q;
	logic signed [31:0] skk_q;
	logic signed [31:0] covl_q;
	logic signed [31:0] sm_q;
	logic signed [31:0] t1_q;
	logic signed [31:0] t2_q;
	logic signed [31:0] mul_q;
	logic signed [39:0] inner_q;
	logic signed [63:0] grad_q;
	logic signed [63:0] curv_q;
	logic signed [31:0] delta_q;
	logic signed [31:0] deriv_q;
	logic               neg_q;
	logic signed [31:0] res_q;
	logic               fault_q;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic [32:0]        mag;
	logic               above;
	logic [31:0]        shr;
	logic [QW-1:0]      dividend;
	logic [31:0]        divisor;
	logic               div_start;
	logic [QW-1:0]      quotient;
	logic               div_done;
	logic               emit;
	logic               out_valid_q;
	logic [2:0]         out_dim_q;
	logic signed [31:0] out_load_q;
	logic               out_last_q;
	logic               out_fault_q;

	// Load addressing; out-of-store loads are dropped.
	assign ld_p = PW'({{PW{1'b0}}, person});
	assign ld_a = DW'({{DW{1'b0}}, dim_a});
	assign ld_b = DW'({{DW{1'b0}}, dim_b});
	assign p_ok = 32'(person) < MAX_PERSONS;
	assign a_ok = 32'(dim_a) < MAX_DIMENSIONS;
	assign b_ok = 32'(dim_b) < MAX_DIMENSIONS;

	assign rd_p = person_idx[PW-1:0];
	assign rd_k = dim_k[DW-1:0];
	assign rd_r = (cmd.op == lcd_pkg::DP_L_RD) ? dim_l[DW-1:0] : rd_k;

	always_ff @(posedge clk) begin
		if (take && p_ok && a_ok) begin
			case (operation)
				lcd_pkg::OP_COV: begin
					if (b_ok)
						cov_mem[{ld_p, ld_a, ld_b}] <= value;
				end
				lcd_pkg::OP_MEAN: mean_mem[{ld_p, ld_a}] <= value;
				lcd_pkg::OP_RESP: begin
					wt_mem[ld_p]   <= value;
					resp_mem[ld_p] <= response;
				end
				default: ;
			endcase
		end
		cov_rd_q  <= cov_mem[{rd_p, rd_r, rd_k}];
		mean_rd_q <= mean_mem[{rd_p, rd_r}];
		wt_rd_q   <= wt_mem[rd_p];
		resp_rd_q <= resp_mem[rd_p];
	end

	// Loading row: cleared by reset, written by start loads and by each result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < MAX_DIMENSIONS; d++)
				row_q[d] <= '0;
		end else if (take && operation == lcd_pkg::OP_LOAD && a_ok) begin
			row_q[ld_a] <= value;
		end else if (emit) begin
			row_q[rd_k] <= res_q;
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		case (cmd.op)
			lcd_pkg::DP_HEAD: begin
				mul_a = mean_rd_q;
				mul_b = mean_rd_q;
			end
			lcd_pkg::DP_C1: begin
				mul_a = resp_q ? HALF : -HALF;
				mul_b = muk_q;
			end
			lcd_pkg::DP_C2: begin
				mul_a = eta_q;
				mul_b = skk_q;
			end
			lcd_pkg::DP_C3: begin
				mul_a = b_q;
				mul_b = eta_q;
			end
			lcd_pkg::DP_C4: begin
				mul_a = mul_q;
				mul_b = muk_q;
			end
			lcd_pkg::DP_L_M1: begin
				mul_a = mean_rd_q;
				mul_b = muk_q;
			end
			lcd_pkg::DP_L_M3: begin
				mul_a = row_q[dim_l[DW-1:0]];
				mul_b = sm_q;
			end
			lcd_pkg::DP_T1: begin
				mul_a = eta_q;
				mul_b = lcd_pkg::sat32(64'(inner_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Soft threshold on the saturated gradient.
	assign mag       = delta_q[31] ? 33'(-64'(delta_q)) : 33'(delta_q);
	assign above     = mag > 33'(penalty);
	assign shr       = 32'(mag - 33'(penalty));
	assign dividend  = QW'(shr) << FRACTION_BITS;
	assign divisor   = deriv_q[31] ? 32'(-64'(deriv_q)) : deriv_q;
	assign div_start = (cmd.op == lcd_pkg::DP_D_CMP) && above && (deriv_q != '0);

	always_ff @(posedge clk) begin
		mul_q <= qmul(mul_a, mul_b);
		case (cmd.op)
			lcd_pkg::DP_IDLE: begin
				if (take)
					b_q <= value;
			end
			lcd_pkg::DP_DIM_CLR: begin
				grad_q <= '0;
				curv_q <= '0;
			end
			lcd_pkg::DP_HEAD: begin
				muk_q   <= mean_rd_q;
				eta_q   <= wt_rd_q;
				resp_q  <= resp_rd_q;
				covkk_q <= cov_rd_q;
				inner_q <= '0;
			end
			lcd_pkg::DP_C1: skk_q <= lcd_pkg::sat32(64'(covkk_q) + 64'(mul_q));
			lcd_pkg::DP_C2: t1_q <= mul_q;
			lcd_pkg::DP_C3: curv_q <= curv_q + 64'(lcd_pkg::sat2(mul_q));
			lcd_pkg::DP_C5: t2_q <= lcd_pkg::sat2(mul_q);
			lcd_pkg::DP_L_M1: covl_q <= cov_rd_q;
			lcd_pkg::DP_L_M2: sm_q <= lcd_pkg::sat32(64'(covl_q) + 64'(mul_q));
			lcd_pkg::DP_L_ACC: inner_q <= inner_q + 40'(mul_q);
			lcd_pkg::DP_T2: grad_q <= grad_q + 64'(t1_q) + 64'(t2_q)
				- 64'(lcd_pkg::sat2(mul_q));
			lcd_pkg::DP_D_SAT: begin
				delta_q <= lcd_pkg::sat32(grad_q);
				deriv_q <= lcd_pkg::sat32(curv_q);
			end
			lcd_pkg::DP_D_CMP: begin
				res_q   <= '0;
				fault_q <= above && (deriv_q == '0);
				neg_q   <= delta_q[31] ^ deriv_q[31];
			end
			lcd_pkg::DP_D_FIN: begin
				if (neg_q)
					res_q <= (quotient > QW'(33'h0_8000_0000)) ? 32'sh8000_0000
						: -$signed(quotient[31:0]);
				else
					res_q <= (quotient > QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
						: $signed(quotient[31:0]);
			end
			default: ;
		endcase
	end

	lcd_div #(
		.W(QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	// Output register: the block moves on while a word waits to be taken.
	assign emit = (cmd.op == lcd_pkg::DP_EMIT) && !(out_valid_q && !out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_dim_q   <= 3'({3'b000, dim_k});
			out_load_q  <= res_q;
			out_last_q  <= cmd.last;
			out_fault_q <= fault_q;
		end
	end

	assign sts.out_busy   = out_valid_q && !out_ready;
	assign sts.div_go     = above && (deriv_q != '0);
	assign sts.div_done   = div_done;
	assign out_valid      = out_valid_q;
	assign out_dimension  = out_dim_q;
	assign out_loading    = out_load_q;
	assign out_last       = out_last_q;
	assign out_fault      = out_fault_q;
endmodule

### hw/rtl/lasso_loading_coordinate_descent.sv
// Top level of the lasso loading coordinate-descent block: register port,
// controller and datapath. Uses lcd_pkg, lcd_item_if, lcd_result_if,
// lcd_ctrl and lcd_datapath.
//
//   Channel  Direction  Word carried
//   item     in         operation, person, dim_a, dim_b, response, value
//   result   out        dimension, loading, last, divide_fault
//   apb      in/out     penalty, persons_in_use, dimensions_in_use
//
// A load word is written to its store at once when it is taken; loads may
// follow one another every cycle while the block is idle. A run word occupies
// the block for each dimension in use with a pass over the persons in use and
// then a division when one is due; the shared multiplier and the store read
// ports set the per-person cost and the bit-serial divider the tail.
// Reset is asynchronous and clears control state and the loading row; the
// person stores hold nothing defined until written and need no clearing.
// While a finished word waits in the output register the block keeps working
// and stalls only when the next word is due and the register is still full.
module lasso_loading_coordinate_descent #(
	parameter int MAX_PERSONS    = 1024,
	parameter int MAX_DIMENSIONS = 8,
	parameter int FRACTION_BITS  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	lcd_item_if.sink     item,
	lcd_result_if.source result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	// Store index widths follow the store sizes; counters also hold the count.
	localparam int PW    = (MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1;
	localparam int DW    = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
	localparam int CNT_W = $clog2(MAX_PERSONS + 1);
	localparam int DC_W  = $clog2(MAX_DIMENSIONS + 1);

	logic [30:0]       penalty_q;
	logic [10:0]       persons_q;
	logic [3:0]        dims_q;
	logic              wr;
	logic [CNT_W-1:0]  np;
	logic [DC_W-1:0]   nd;
	logic              take;
	lcd_pkg::lcd_cmd_t cmd;
	lcd_pkg::lcd_sts_t sts;
	logic [CNT_W-1:0]  person_idx;
	logic [DC_W-1:0]   dim_k;
	logic [DC_W-1:0]   dim_l;

	// Register writes land on the access cycle; unmapped addresses are ignored.
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			penalty_q <= '0;
			persons_q <= 11'd1024;
			dims_q    <= 4'd8;
		end else if (wr) begin
			case (paddr[3:2])
				lcd_pkg::REG_PENALTY: penalty_q <= pwdata[30:0];
				lcd_pkg::REG_PERSONS: persons_q <= pwdata[10:0];
				lcd_pkg::REG_DIMS:    dims_q    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			lcd_pkg::REG_PENALTY: prdata = {1'b0, penalty_q};
			lcd_pkg::REG_PERSONS: prdata = {21'd0, persons_q};
			lcd_pkg::REG_DIMS:    prdata = {28'd0, dims_q};
			default:              prdata = '0;
		endcase
	end

	// Counts out of range are pulled into 1 .. maximum.
	assign np = (persons_q == '0) ? CNT_W'(1)
		: (32'(persons_q) > MAX_PERSONS) ? CNT_W'(MAX_PERSONS) : CNT_W'(persons_q);
	assign nd = (dims_q == '0) ? DC_W'(1)
		: (32'(dims_q) > MAX_DIMENSIONS) ? DC_W'(MAX_DIMENSIONS) : DC_W'(dims_q);

	assign take = item.valid && item.ready;

	lcd_ctrl #(
		.CNT_W(CNT_W),
		.DC_W (DC_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_op    (item.operation),
		.np         (np),
		.nd         (nd),
		.sts        (sts),
		.item_ready (item.ready),
		.cmd        (cmd),
		.person_idx (person_idx),
		.dim_k      (dim_k),
		.dim_l      (dim_l)
	);

	lcd_datapath #(
		.MAX_PERSONS   (MAX_PERSONS),
		.MAX_DIMENSIONS(MAX_DIMENSIONS),
		.FRACTION_BITS (FRACTION_BITS),
		.PW            (PW),
		.DW            (DW),
		.CNT_W         (CNT_W),
		.DC_W          (DC_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.operation     (item.operation),
		.person        (item.person),
		.dim_a         (item.dim_a),
		.dim_b         (item.dim_b),
		.response      (item.response),
		.value         (item.value),
		.penalty       (penalty_q),
		.cmd           (cmd),
		.person_idx    (person_idx),
		.dim_k         (dim_k),
		.dim_l         (dim_l),
		.sts           (sts),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.out_dimension (result.dimension),
		.out_loading   (result.loading),
		.out_last      (result.last),
		.out_fault     (result.divide_fault)
	);
endmodule

### hw/rtl/lcd_checker.sv
// Port-level checks for the lasso loading block, bound to its top level.
// Depends on lcd_pkg and lasso_loading_coordinate_descent.
module lcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic [2:0]  item_operation,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] result_loading,
	input logic        result_fault
);
	// A waiting result word is not withdrawn.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word dropped before it was taken");

	// A run word makes the block busy on the next cycle.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_operation == lcd_pkg::OP_RUN |=> !item_ready)
		else $error("block still ready after a run word");

	// Load words never stall the input.
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_operation != lcd_pkg::OP_RUN |=> item_ready)
		else $error("block not ready after a load word");

	// A division fault always carries a zero loading.
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_fault |-> result_loading == 32'd0)
		else $error("faulted result with non-zero loading");
endmodule

bind lasso_loading_coordinate_descent lcd_checker u_lcd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.item_operation (item.operation),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_loading (result.loading),
	.result_fault   (result.divide_fault)
);
